### src/rfo_pkg.sv
// ----------------------------------------------------------------------------
// Rotor flux observer package
// Shared types, codes and constants of the RK4 rotor flux observer.
// ----------------------------------------------------------------------------
package rfo_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 32;

  // Multiplier B operand is consumed in digits, one digit per cycle.
  localparam int unsigned MUL_DIG_W  = 10;
  localparam int unsigned MUL_DIGITS = 4;
  localparam int unsigned MUL_BW     = MUL_DIG_W * MUL_DIGITS;
  localparam int unsigned MUL_CNT_W  = $clog2(MUL_DIGITS);

  localparam logic [31:0] INV_SQRT3_Q32 = 32'd2479700525;
  localparam logic [31:0] STEP_RESET    = 32'd429497;
  localparam logic [4:0]  POLES_RESET   = 5'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_SIZE  = 2'd0,
    REG_DECAY_COEF = 2'd1,
    REG_GAIN_COEF  = 2'd2,
    REG_POLE_PAIRS = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SH16 = 2'd0,
    SH32 = 2'd1,
    SH33 = 2'd2
  } shift_e;

  typedef enum logic {
    DIV3 = 1'b0,
    DIV6 = 1'b1
  } div_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ISSUE = 2'd1,
    ST_WAIT  = 2'd2,
    ST_FIN   = 2'd3
  } seq_state_e;

  typedef enum logic [3:0] {
    UOP_IALPHA   = 4'd0,
    UOP_IBETA    = 4'd1,
    UOP_GIA      = 4'd2,
    UOP_GIB      = 4'd3,
    UOP_SLA1     = 4'd4,
    UOP_SLA2     = 4'd5,
    UOP_SLB1     = 4'd6,
    UOP_SLB2     = 4'd7,
    UOP_HALFA    = 4'd8,
    UOP_HALFB    = 4'd9,
    UOP_FINA_MUL = 4'd10,
    UOP_FINA_DIV = 4'd11,
    UOP_FINB_MUL = 4'd12,
    UOP_FINB_DIV = 4'd13
  } uop_e;

  typedef struct packed {
    logic   start;
    shift_e shift;
  } mul_ctl_t;

  typedef struct packed {
    logic start;
    div_e sel;
  } div_ctl_t;

  typedef struct packed {
    logic signed [31:0] phase_current_a;
    logic signed [31:0] phase_current_b;
    logic signed [31:0] phase_current_c;
    logic signed [31:0] mech_speed;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] flux_alpha;
    logic signed [31:0] flux_beta;
  } out_word_t;

endpackage

### src/rfo_mul.sv
// ----------------------------------------------------------------------------
// Rotor flux observer multiplier
// Sign-magnitude multiplier, one B digit per cycle, with a rounding shift
// (half away from zero) and a magnitude clamp.
// ----------------------------------------------------------------------------
module rfo_mul import rfo_pkg::*; #(
  parameter int unsigned AW = 35,
  parameter int unsigned RW = 36
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mul_ctl_t                 ctl_i,
  input  logic signed [AW-1:0]     a_i,
  input  logic signed [MUL_BW-1:0] b_i,
  output logic                     done_o,
  output logic signed [RW-1:0]     r_o
);

  localparam int unsigned PW = AW + MUL_BW;
  localparam int unsigned MW = PW + 1;
  localparam logic [MW-1:0] LIMIT = MW'(1) << (RW - 2);

  logic [AW-1:0]         ma_q;
  logic [MUL_BW-1:0]     mb_q;
  logic [PW-1:0]         acc_q, acc_d;
  logic [MUL_CNT_W-1:0]  cnt_q;
  logic                  neg_q, busy_q, fin_q, done_q;
  shift_e                shift_q;
  logic signed [RW-1:0]  r_q, r_d;
  logic [AW+MUL_DIG_W-1:0] pp;
  logic [MW-1:0]         rnd, mag, magc;

  assign pp    = ma_q * mb_q[cnt_q*MUL_DIG_W +: MUL_DIG_W];
  assign acc_d = acc_q + (PW'(pp) << (cnt_q * MUL_DIG_W));

  always_comb begin
    case (shift_q)
      SH16: begin
        rnd = MW'(acc_q) + (MW'(1) << 15);
        mag = rnd >> 16;
      end
      SH32: begin
        rnd = MW'(acc_q) + (MW'(1) << 31);
        mag = rnd >> 32;
      end
      SH33: begin
        rnd = MW'(acc_q) + (MW'(1) << 32);
        mag = rnd >> 33;
      end
      default: begin
        rnd = MW'(acc_q);
        mag = rnd;
      end
    endcase
    magc = (mag > LIMIT) ? LIMIT : mag;
    r_d  = neg_q ? -RW'(magc) : RW'(magc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      fin_q   <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      acc_q   <= '0;
      ma_q    <= '0;
      mb_q    <= '0;
      neg_q   <= 1'b0;
      shift_q <= SH16;
      r_q     <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (ctl_i.start) begin
        ma_q    <= a_i[AW-1] ? AW'(-a_i) : AW'(a_i);
        mb_q    <= b_i[MUL_BW-1] ? MUL_BW'(-b_i) : MUL_BW'(b_i);
        neg_q   <= a_i[AW-1] ^ b_i[MUL_BW-1];
        shift_q <= ctl_i.shift;
        acc_q   <= '0;
        cnt_q   <= '0;
        busy_q  <= 1'b1;
      end else if (busy_q) begin
        acc_q <= acc_d;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == MUL_CNT_W'(MUL_DIGITS - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
      if (fin_q) begin
        r_q <= r_d;
      end
    end
  end

  assign done_o = done_q;
  assign r_o    = r_q;

endmodule

### src/rfo_div.sv
// ----------------------------------------------------------------------------
// Rotor flux observer constant divider
// Division of an unsigned value by three or six through a multiply by the
// reciprocal of three, one 16-bit reciprocal digit per cycle.
// ----------------------------------------------------------------------------
module rfo_div import rfo_pkg::*; #(
  parameter int unsigned XW = 35
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  div_ctl_t      ctl_i,
  input  logic [XW-1:0] x_i,
  output logic          done_o,
  output logic [XW-1:0] q_o
);

  localparam int unsigned DIG_W = 16;
  localparam int unsigned RB    = XW + 1;
  localparam int unsigned ND    = (RB + DIG_W - 1) / DIG_W;
  localparam int unsigned RBP   = ND * DIG_W;
  localparam int unsigned PW    = XW + RBP;
  localparam int unsigned CW    = $clog2(ND);
  // The reciprocal of three is rounded up and scaled by 2^(XW+2), which makes
  // the truncated product equal to the floor of x/3 for every XW-bit input.
  localparam logic [XW+2:0]  SCALE  = {1'b1, {(XW+2){1'b0}}};
  localparam logic [RBP-1:0] RECIP3 = RBP'(SCALE / (XW+3)'(3) + (XW+3)'(1));

  logic [XW-1:0]       x_q, q_q, q3, q_d;
  logic [PW-1:0]       acc_q, acc_d;
  logic [XW+DIG_W-1:0] pp;
  logic [CW-1:0]       cnt_q;
  logic                busy_q, fin_q, done_q, half_q;

  assign pp    = x_q * RECIP3[cnt_q*DIG_W +: DIG_W];
  assign acc_d = acc_q + (PW'(pp) << (cnt_q * DIG_W));
  assign q3    = XW'(acc_q >> (XW + 2));
  // A divide by six halves the quotient by three.
  assign q_d   = half_q ? (q3 >> 1) : q3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      acc_q  <= '0;
      x_q    <= '0;
      half_q <= 1'b0;
      q_q    <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (ctl_i.start) begin
        x_q    <= x_i;
        half_q <= (ctl_i.sel == DIV6);
        acc_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        acc_q <= acc_d;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(ND - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
      if (fin_q) begin
        q_q <= q_d;
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

### src/rotor_flux_rk4_observer_core.sv
// ----------------------------------------------------------------------------
// Rotor flux RK4 observer core
// Clarke transform and one RK4 step of the current-velocity flux model per
// word, sequenced over one shared multiplier and one constant divider.
// ----------------------------------------------------------------------------
// Each word runs 27 multiplies and 3 divides, each divide over ND = ceil((XW+1)/16)
// reciprocal digits (3 here), and then the result load. One word is in flight at a time:
// in_stall_o is high from accept until the result is loaded, which waits while a previous
// result is still stalled.
// Reset clears flux state to zero and loads register defaults.
module rotor_flux_rk4_observer_core import rfo_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned XW = (DW + 3 > 35) ? DW + 3 : 35;
  localparam int unsigned WW = XW + 2;
  localparam int unsigned RW = DW + 4;
  localparam int unsigned SW = DW + 3;

  function automatic logic signed [DW-1:0] sat_dw(input logic signed [WW-1:0] v);
    logic signed [DW-1:0] r;
    if (v[WW-1:DW-1] == '0 || v[WW-1:DW-1] == '1) begin
      r = v[DW-1:0];
    end else begin
      r = v[WW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_out(input logic signed [WW-1:0] v);
    logic signed [31:0] r;
    if (v[WW-1:31] == '0 || v[WW-1:31] == '1) begin
      r = v[31:0];
    end else begin
      r = v[WW-1] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

  seq_state_e state_q, state_d;
  uop_e       uop_q, uop_d;
  logic [1:0] stage_q, stage_d;

  logic [31:0]        step_q, step_d;
  logic signed [31:0] decay_q, decay_d, gain_q, gain_d;
  logic [4:0]         poles_q, poles_d;

  logic signed [DW-1:0] pa_q, pa_d, pb_q, pb_d, xa_q, xa_d, xb_q, xb_d;
  logic signed [DW-1:0] ia_q, ia_d, ib_q, ib_d, gia_q, gia_d, gib_q, gib_d;
  logic signed [DW-1:0] t_q, t_d, ka_q, ka_d, kb_q, kb_d;
  logic signed [SW-1:0] suma_q, suma_d, sumb_q, sumb_d;
  logic signed [RW-1:0] q_q, q_d;
  logic signed [33:0]   na_q, na_d;
  logic signed [32:0]   nb_q, nb_d;
  logic signed [37:0]   w_q, w_d;

  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q, out_word_d;

  mul_ctl_t                 mul_ctl;
  div_ctl_t                 div_ctl;
  logic signed [XW-1:0]     mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  shift_e                   mul_shift;
  logic                     is_div;
  logic [XW-1:0]            div_x;
  div_e                     div_sel;
  logic                     mul_done, div_done;
  logic signed [RW-1:0]     mul_r;
  logic [XW-1:0]            div_q;

  logic [33:0]          na_mag;
  logic [RW-1:0]        q_mag;
  logic signed [DW-1:0] mr_sat, dv_sat, kb_new;
  logic signed [WW-1:0] dpos, dsig;
  logic                 dbl;

  assign na_mag = na_q[33] ? 34'(-na_q) : 34'(na_q);
  assign q_mag  = q_q[RW-1] ? RW'(-q_q) : RW'(q_q);
  assign mr_sat = sat_dw(WW'(mul_r));
  assign dpos   = WW'(div_q);
  assign dsig   = ((uop_q == UOP_IALPHA) ? na_q[33] : q_q[RW-1]) ? -dpos : dpos;
  assign dv_sat = sat_dw(dsig);
  assign dbl    = (stage_q == 2'd1) || (stage_q == 2'd2);

  // Operand selection for the current micro-step.
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mul_shift = SH16;
    is_div    = 1'b0;
    div_x     = '0;
    div_sel   = DIV3;
    case (uop_q)
      UOP_IALPHA: begin
        is_div = 1'b1;
        div_x  = XW'(na_mag) + XW'(1);
      end
      UOP_IBETA: begin
        mul_a     = XW'(nb_q);
        mul_b     = MUL_BW'(INV_SQRT3_Q32);
        mul_shift = SH32;
      end
      UOP_GIA: begin
        mul_a = XW'(ia_q);
        mul_b = MUL_BW'(gain_q);
      end
      UOP_GIB: begin
        mul_a = XW'(ib_q);
        mul_b = MUL_BW'(gain_q);
      end
      UOP_SLA1: begin
        mul_a = XW'(xb_q);
        mul_b = MUL_BW'(w_q);
      end
      UOP_SLA2: begin
        mul_a = XW'(xa_q);
        mul_b = MUL_BW'(decay_q);
      end
      UOP_SLB1: begin
        mul_a = XW'(xa_q);
        mul_b = MUL_BW'(w_q);
      end
      UOP_SLB2: begin
        mul_a = XW'(xb_q);
        mul_b = MUL_BW'(decay_q);
      end
      UOP_HALFA: begin
        mul_a     = XW'(ka_q);
        mul_b     = MUL_BW'(step_q);
        mul_shift = (stage_q == 2'd2) ? SH32 : SH33;
      end
      UOP_HALFB: begin
        mul_a     = XW'(kb_q);
        mul_b     = MUL_BW'(step_q);
        mul_shift = (stage_q == 2'd2) ? SH32 : SH33;
      end
      UOP_FINA_MUL: begin
        mul_a     = XW'(suma_q);
        mul_b     = MUL_BW'(step_q);
        mul_shift = SH32;
      end
      UOP_FINB_MUL: begin
        mul_a     = XW'(sumb_q);
        mul_b     = MUL_BW'(step_q);
        mul_shift = SH32;
      end
      UOP_FINA_DIV, UOP_FINB_DIV: begin
        is_div  = 1'b1;
        div_x   = XW'(q_mag) + XW'(3);
        div_sel = DIV6;
      end
      default: begin
        is_div = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    uop_d       = uop_q;
    stage_d     = stage_q;
    step_d      = step_q;
    decay_d     = decay_q;
    gain_d      = gain_q;
    poles_d     = poles_q;
    pa_d        = pa_q;
    pb_d        = pb_q;
    xa_d        = xa_q;
    xb_d        = xb_q;
    ia_d        = ia_q;
    ib_d        = ib_q;
    gia_d       = gia_q;
    gib_d       = gib_q;
    t_d         = t_q;
    ka_d        = ka_q;
    kb_d        = kb_q;
    suma_d      = suma_q;
    sumb_d      = sumb_q;
    q_d         = q_q;
    na_d        = na_q;
    nb_d        = nb_q;
    w_d         = w_q;
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q;
    kb_new      = sat_dw(WW'(t_q) - WW'(mr_sat));
    mul_ctl     = '{start: 1'b0, shift: mul_shift};
    div_ctl     = '{start: 1'b0, sel: div_sel};

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          na_d = (34'(in_word_i.phase_current_a) <<< 1)
                 - 34'(in_word_i.phase_current_b) - 34'(in_word_i.phase_current_c);
          nb_d = 33'(in_word_i.phase_current_b) - 33'(in_word_i.phase_current_c);
          w_d  = 38'(in_word_i.mech_speed) * $signed(38'(poles_q));
          xa_d    = pa_q;
          xb_d    = pb_q;
          suma_d  = '0;
          sumb_d  = '0;
          stage_d = 2'd0;
          uop_d   = UOP_IALPHA;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (is_div) begin
          div_ctl.start = 1'b1;
        end else begin
          mul_ctl.start = 1'b1;
        end
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (mul_done || div_done) begin
          state_d = ST_ISSUE;
          case (uop_q)
            UOP_IALPHA: begin
              ia_d  = dv_sat;
              uop_d = UOP_IBETA;
            end
            UOP_IBETA: begin
              ib_d  = mr_sat;
              uop_d = UOP_GIA;
            end
            UOP_GIA: begin
              gia_d = mr_sat;
              uop_d = UOP_GIB;
            end
            UOP_GIB: begin
              gib_d = mr_sat;
              uop_d = UOP_SLA1;
            end
            UOP_SLA1: begin
              t_d   = sat_dw(WW'(gia_q) - WW'(mr_sat));
              uop_d = UOP_SLA2;
            end
            UOP_SLA2: begin
              ka_d  = sat_dw(WW'(t_q) - WW'(mr_sat));
              uop_d = UOP_SLB1;
            end
            UOP_SLB1: begin
              t_d   = sat_dw(WW'(gib_q) + WW'(mr_sat));
              uop_d = UOP_SLB2;
            end
            UOP_SLB2: begin
              // Slopes are weighted 1, 2, 2, 1 into the exact RK4 sums.
              kb_d   = kb_new;
              suma_d = SW'(WW'(suma_q) + (dbl ? (WW'(ka_q) <<< 1) : WW'(ka_q)));
              sumb_d = SW'(WW'(sumb_q) + (dbl ? (WW'(kb_new) <<< 1) : WW'(kb_new)));
              uop_d  = (stage_q == 2'd3) ? UOP_FINA_MUL : UOP_HALFA;
            end
            UOP_HALFA: begin
              xa_d  = sat_dw(WW'(pa_q) + WW'(mr_sat));
              uop_d = UOP_HALFB;
            end
            UOP_HALFB: begin
              xb_d    = sat_dw(WW'(pb_q) + WW'(mr_sat));
              stage_d = stage_q + 2'd1;
              uop_d   = UOP_SLA1;
            end
            UOP_FINA_MUL: begin
              q_d   = mul_r;
              uop_d = UOP_FINA_DIV;
            end
            UOP_FINA_DIV: begin
              pa_d  = sat_dw(WW'(pa_q) + WW'(dv_sat));
              uop_d = UOP_FINB_MUL;
            end
            UOP_FINB_MUL: begin
              q_d   = mul_r;
              uop_d = UOP_FINB_DIV;
            end
            UOP_FINB_DIV: begin
              pb_d    = sat_dw(WW'(pb_q) + WW'(dv_sat));
              state_d = ST_FIN;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_word_d.flux_alpha = sat_out(WW'(pa_q));
          out_word_d.flux_beta  = sat_out(WW'(pb_q));
          out_valid_d           = 1'b1;
          state_d               = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_STEP_SIZE:  step_d  = cfg_data_i;
        REG_DECAY_COEF: decay_d = cfg_data_i;
        REG_GAIN_COEF:  gain_d  = cfg_data_i;
        REG_POLE_PAIRS: poles_d = cfg_data_i[4:0];
        default: begin
          step_d = step_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      uop_q       <= UOP_IALPHA;
      stage_q     <= 2'd0;
      step_q      <= STEP_RESET;
      decay_q     <= '0;
      gain_q      <= '0;
      poles_q     <= POLES_RESET;
      pa_q        <= '0;
      pb_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      uop_q       <= uop_d;
      stage_q     <= stage_d;
      step_q      <= step_d;
      decay_q     <= decay_d;
      gain_q      <= gain_d;
      poles_q     <= poles_d;
      pa_q        <= pa_d;
      pb_q        <= pb_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xa_q       <= xa_d;
    xb_q       <= xb_d;
    ia_q       <= ia_d;
    ib_q       <= ib_d;
    gia_q      <= gia_d;
    gib_q      <= gib_d;
    t_q        <= t_d;
    ka_q       <= ka_d;
    kb_q       <= kb_d;
    suma_q     <= suma_d;
    sumb_q     <= sumb_d;
    q_q        <= q_d;
    na_q       <= na_d;
    nb_q       <= nb_d;
    w_q        <= w_d;
    out_word_q <= out_word_d;
  end

  rfo_mul #(
    .AW (XW),
    .RW (RW)
  ) u_rfo_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mul_ctl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .r_o    (mul_r)
  );

  rfo_div #(
    .XW (XW)
  ) u_rfo_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .x_i    (div_x),
    .done_o (div_done),
    .q_o    (div_q)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

### src/rfo_checker.sv
// ----------------------------------------------------------------------------
// Rotor flux observer port checker
// Temporal checks on the observer's ports, bound to the top level.
// ----------------------------------------------------------------------------
module rfo_checker import rfo_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input in_word_t              in_word_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input out_word_t             out_word_o,
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  // The block works on one word at a time, so it stalls right after accepting.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o ##1 in_stall_o)
    else $error("input not stalled while a word is in flight");

  // A new result only appears at the end of a computation.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a word in flight");

  // No result appears in the cycle right after a word is accepted.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_o))
    else $error("result appeared too early");

endmodule

bind rotor_flux_rk4_observer_core rfo_checker u_rfo_checker (.*);

### tb/rotor_flux_rk4_observer_core_tb.sv
// ----------------------------------------------------------------------------
// Rotor flux RK4 observer core testbench
// Drives phase current and speed words through the core under random gaps and
// stalls, predicts each flux word with a fixed-point RK4 model kept in a small
// scoreboard, and compares every result field by field in order.
// ----------------------------------------------------------------------------
module rotor_flux_rk4_observer_core_tb import rfo_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint QMAX     = 64'sd2147483647;
  localparam longint QMIN     = -64'sd2147483648;
  localparam int     LIMIT    = 3000000;
  localparam int     DRAIN    = 400;
  localparam int     HOLD_LEN = 1500;

  class flux_scoreboard;
    longint    step_h, decay, gain, poles;
    longint    psi_a, psi_b;
    out_word_t flux_q[$];

    function new();
      step_h = STEP_RESET;
      decay  = 0;
      gain   = 0;
      poles  = POLES_RESET;
      psi_a  = 0;
      psi_b  = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [31:0] v);
      case (idx)
        REG_STEP_SIZE:  step_h = longint'({32'd0, v});
        REG_DECAY_COEF: decay  = longint'(signed'(v));
        REG_GAIN_COEF:  gain   = longint'(signed'(v));
        REG_POLE_PAIRS: poles  = longint'(v[4:0]);
        default: ;
      endcase
    endfunction

    function longint sat(longint v);
      if (v > QMAX) return QMAX;
      if (v < QMIN) return QMIN;
      return v;
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    // Product shifted right by s, rounded half away from zero, magnitude clamped at 2^62.
    function longint mul_rnd(longint a, longint b, int unsigned s);
      logic [127:0] p;
      longint       r;
      p = {64'd0, mag(a)} * {64'd0, mag(b)} + (128'd1 << (s - 1));
      p = p >> s;
      if (p > (128'd1 << 62)) p = 128'd1 << 62;
      r = longint'(p[63:0]);
      return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function void slope(longint pa, longint pb, longint ia, longint ib, longint w,
                        output longint da, output longint db);
      longint t;
      t  = sat(sat(mul_rnd(ia, gain, 16)) - sat(mul_rnd(pb, w, 16)));
      da = sat(t - sat(mul_rnd(pa, decay, 16)));
      t  = sat(sat(mul_rnd(ib, gain, 16)) + sat(mul_rnd(pa, w, 16)));
      db = sat(t - sat(mul_rnd(pb, decay, 16)));
    endfunction

    function longint advance(longint p, longint sum);
      longint q, d;
      longint unsigned m;
      q = mul_rnd(sum, step_h, 32);
      m = (mag(q) + 3) / 6;
      d = q < 0 ? -longint'(m) : longint'(m);
      return sat(p + sat(d));
    endfunction

    function void note_input(in_word_t w);
      longint          a, b, c, n, ia, ib, we, pa, pb;
      longint          k1a, k1b, k2a, k2b, k3a, k3b, k4a, k4b;
      longint unsigned m;
      logic [127:0]    pr;
      out_word_t       o;
      a  = w.phase_current_a;
      b  = w.phase_current_b;
      c  = w.phase_current_c;
      pa = psi_a;
      pb = psi_b;
      n  = 2 * a - b - c;
      m  = (mag(n) + 1) / 3;
      ia = sat(n < 0 ? -longint'(m) : longint'(m));
      n  = b - c;
      pr = ({64'd0, mag(n)} * {96'd0, INV_SQRT3_Q32} + (128'd1 << 31)) >> 32;
      m  = pr[63:0];
      ib = sat(n < 0 ? -longint'(m) : longint'(m));
      we = longint'(w.mech_speed) * poles;
      slope(pa, pb, ia, ib, we, k1a, k1b);
      slope(sat(pa + sat(mul_rnd(k1a, step_h, 33))), sat(pb + sat(mul_rnd(k1b, step_h, 33))),
            ia, ib, we, k2a, k2b);
      slope(sat(pa + sat(mul_rnd(k2a, step_h, 33))), sat(pb + sat(mul_rnd(k2b, step_h, 33))),
            ia, ib, we, k3a, k3b);
      slope(sat(pa + sat(mul_rnd(k3a, step_h, 32))), sat(pb + sat(mul_rnd(k3b, step_h, 32))),
            ia, ib, we, k4a, k4b);
      psi_a = advance(pa, k1a + 2 * k2a + 2 * k3a + k4a);
      psi_b = advance(pb, k1b + 2 * k2b + 2 * k3b + k4b);
      o.flux_alpha = psi_a[31:0];
      o.flux_beta  = psi_b[31:0];
      flux_q.push_back(o);
    endfunction

    function void check(out_word_t got, ref string errs[$]);
      out_word_t e;
      if (flux_q.size() == 0) begin
        errs.push_back($sformatf("unexpected word %h", got));
        return;
      end
      e = flux_q.pop_front();
      if (got.flux_alpha !== e.flux_alpha)
        errs.push_back($sformatf("flux_alpha %h, expected %h", got.flux_alpha, e.flux_alpha));
      if (got.flux_beta !== e.flux_beta)
        errs.push_back($sformatf("flux_beta %h, expected %h", got.flux_beta, e.flux_beta));
    endfunction

    function int pending();
      return flux_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_word = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  flux_scoreboard sb = new();
  int  errors = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;

  rotor_flux_rk4_observer_core u_top (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report(string msg);
    errors++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    string errs[$];
    if (rst_ni && out_valid && !out_stall) begin
      errs.delete();
      sb.check(out_word, errs);
      foreach (errs[i]) report(errs[i]);
    end
  end

  // Receiver: a random hold-off before each word, or one long stretch on request.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 3);
      if (hold_req) begin
        n = HOLD_LEN;
        hold_req = 1'b0;
      end
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send(in_word_t w);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_word  = w;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_input(w);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] v);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = v;
    @(posedge clk);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(logic [31:0] h, logic [31:0] d, logic [31:0] g, logic [31:0] p);
    write_reg(REG_STEP_SIZE, h);
    write_reg(REG_DECAY_COEF, d);
    write_reg(REG_GAIN_COEF, g);
    write_reg(REG_POLE_PAIRS, p);
  endtask

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'(signed'($urandom) >>> $urandom_range(6, 31));
    endcase
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    w.phase_current_a = rand_q16();
    w.phase_current_b = rand_q16();
    w.phase_current_c = rand_q16();
    w.mech_speed      = rand_q16();
    return w;
  endfunction

  function automatic in_word_t mk(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                  logic [31:0] s);
    in_word_t w;
    w.phase_current_a = a;
    w.phase_current_b = b;
    w.phase_current_c = c;
    w.mech_speed      = s;
    return w;
  endfunction

  initial begin
    logic [31:0] h;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // Register defaults first: zero gains leave the flux at zero.
    send(mk(32'h0001_0000, 32'h0, 32'h0, 32'h0010_0000));
    send(mk(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
    wait_idle();

    // Largest step, gain and pole count drive the flux into saturation.
    configure(32'hffff_ffff, 32'h0, 32'h7fff_ffff, 32'd31);
    send(mk(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send(mk(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send(mk(32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0));
    send(mk(32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff));
    send(mk(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h0001_0000));
    wait_idle();

    configure(32'hffff_ffff, 32'h8000_0000, 32'h8000_0000, 32'd17);
    send(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    send(mk(32'h0, 32'h0, 32'h0, 32'h0));
    send(mk(32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h8000_0000));
    wait_idle();

    // Zero step keeps the flux, and zero pole pairs give no rotation.
    configure(32'h0, 32'h7fff_ffff, 32'h7fff_ffff, 32'd0);
    send(mk(32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h7fff_ffff));
    send(mk(32'h1234_5678, 32'h8765_4321, 32'h0, 32'h8000_0000));
    wait_idle();

    configure(32'd429497, 32'h0008_0000, 32'h0002_0000, 32'd0);
    send(mk(32'h0005_0000, 32'hfffe_0000, 32'hfffd_0000, 32'h0064_0000));
    send(mk(32'h0005_0000, 32'hfffe_0000, 32'hfffd_0000, 32'h0064_0000));
    send(mk(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001));
    send(mk(32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 32'hffff_ffff));
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 3))
        0: h = $urandom;
        1: h = $urandom_range(0, 32'h0100_0000);
        default: h = $urandom_range(0, 32'h0010_0000);
      endcase
      configure(h, rand_q16(), rand_q16(),
                $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(1, 16));
      quiet = (ph == 2);
      for (int i = 0; i < 300; i++) begin
        if (ph == 3 && i == 10) hold_req = 1'b1;
        send(rand_word());
      end
      quiet = 1'b0;
      wait_idle();
    end

    if (sb.pending() != 0) report("results still expected at the end");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
src/rfo_pkg.sv
src/rfo_mul.sv
src/rfo_div.sv
src/rotor_flux_rk4_observer_core.sv
src/rfo_checker.sv
tb/rotor_flux_rk4_observer_core_tb.sv
